>>> sv/anrr_pkg.sv
// ----------------------------------------------------------------------------
// anrr_pkg: shared types and constants for the aging node table
// Entry layout, state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package anrr_pkg;

  // default number of table entries
  localparam int TABLE_DEPTH_DEF = 16;

  // register values after reset
  localparam logic [31:0] STALE_TIMEOUT_RST = 32'd3000;
  localparam logic [31:0] POLL_PERIOD_RST   = 32'd50;

  // shortest report that is stored
  localparam logic [7:0] MIN_PACKET_LEN = 8'd20;

  // item opcodes
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // configuration register indexes
  localparam logic CFG_STALE_TIMEOUT = 1'b0;
  localparam logic CFG_POLL_PERIOD   = 1'b1;

  // one stored report
  typedef struct packed {
    logic [23:0] id;
    logic [31:0] sender;
    logic [31:0] distance;
    logic [31:0] ang;
    logic [31:0] spd;
    logic        det;
    logic [31:0] seen;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_WRITE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

>>> sv/anrr_in_if.sv
// ----------------------------------------------------------------------------
// anrr_in_if: input channel of the aging node table
// Carries one receive or poll word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface anrr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_ms;
  logic [23:0] node_id;
  logic [31:0] sender_ms;
  logic [31:0] distance_bits;
  logic [31:0] angle_bits;
  logic [31:0] speed_bits;
  logic        target_seen;
  logic [7:0]  packet_length;

  modport source (
    output valid, op, now_ms, node_id, sender_ms, distance_bits, angle_bits,
           speed_bits, target_seen, packet_length,
    input  ready
  );

  modport sink (
    input  valid, op, now_ms, node_id, sender_ms, distance_bits, angle_bits,
           speed_bits, target_seen, packet_length,
    output ready
  );
endinterface

>>> sv/anrr_out_if.sv
// ----------------------------------------------------------------------------
// anrr_out_if: result channel of the aging node table
// Carries one node report word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface anrr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] out_node_id;
  logic [31:0] out_sender_ms;
  logic [31:0] out_distance_bits;
  logic [31:0] out_angle_bits;
  logic [31:0] out_speed_bits;
  logic        out_target_seen;

  modport source (
    output valid, out_node_id, out_sender_ms, out_distance_bits, out_angle_bits,
           out_speed_bits, out_target_seen,
    input  ready
  );

  modport sink (
    input  valid, out_node_id, out_sender_ms, out_distance_bits, out_angle_bits,
           out_speed_bits, out_target_seen,
    output ready
  );
endinterface

>>> sv/aging_node_table_round_robin.sv
// ----------------------------------------------------------------------------
// aging_node_table_round_robin: node report table with aging and readout
// Stores reports by node id in arrival order, prunes stale entries on poll
// and hands out one report per productive poll in round-robin order.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | carries
//  ---------+-----------+--------------------+-------------------------------
//  in_ch    | in        | valid/ready        | receive or poll word
//  out_ch   | out       | valid/ready        | chosen node report
//  cfg_*    | in        | cfg_we, no stall   | stale timeout, poll period
//
//  A receive compares entries in turn (SRCH_RD, SRCH_CHK), then WRITE; a
//  productive poll checks every entry (PRUNE_RD, PRUNE_CHK), then PICK and
//  EMIT. Both read the table memory one entry at a time through one compare
//  unit. in_ch.ready is high only in idle. A waiting result sits in the
//  output register; a new poll stalls only at its final step until that
//  word is taken. Reset (rst_n, synchronous) empties the table at once.
//
module aging_node_table_round_robin #(
  parameter int TABLE_DEPTH = anrr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  anrr_in_if.sink     in_ch,
  anrr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // table memory
  anrr_pkg::entry_t mem [TABLE_DEPTH];
  anrr_pkg::entry_t rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  anrr_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // control and working registers
  anrr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rr_r, rr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [31:0]      next_poll_r, next_poll_nxt;
  logic [31:0]      stale_timeout_r;
  logic [31:0]      poll_period_r;
  anrr_pkg::entry_t item_r, item_nxt;
  logic             item_ld;

  // output register
  logic             out_valid_r, out_valid_nxt;
  anrr_pkg::entry_t out_q;
  logic             out_ld;

  // shared datapath terms
  logic [31:0]      poll_diff;
  logic [31:0]      age;
  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W-1:0] rr_adj;
  logic [IDX_W-1:0] rr_sel;
  logic             in_acc;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign poll_diff = in_ch.now_ms - next_poll_r;
  assign age       = item_r.seen - rd_q.seen;
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign rr_adj    = (CNT_W'(rr_r) > wr_ptr_r) ? rr_r - IDX_W'(1) : rr_r;
  assign rr_sel    = (CNT_W'(rr_r) >= cnt_r) ? '0 : rr_r;

  assign in_ch.ready = (state_r == anrr_pkg::ST_IDLE);

  // write and read the table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_timeout_r <= anrr_pkg::STALE_TIMEOUT_RST;
      poll_period_r   <= anrr_pkg::POLL_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        anrr_pkg::CFG_STALE_TIMEOUT: stale_timeout_r <= cfg_wdata;
        anrr_pkg::CFG_POLL_PERIOD:   poll_period_r   <= cfg_wdata;
        default:                     poll_period_r   <= poll_period_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= anrr_pkg::ST_IDLE;
      cnt_r       <= '0;
      rr_r        <= '0;
      next_poll_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rr_r        <= rr_nxt;
      next_poll_r <= next_poll_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers and payload
  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    pos_r    <= pos_nxt;
    if (item_ld) begin
      item_r <= item_nxt;
    end
    if (out_ld) begin
      out_q <= rd_q;
    end
  end

  // latch the incoming word as a table entry
  always_comb begin
    item_nxt.id       = in_ch.node_id;
    item_nxt.sender   = in_ch.sender_ms;
    item_nxt.distance = in_ch.distance_bits;
    item_nxt.ang      = in_ch.angle_bits;
    item_nxt.spd      = in_ch.speed_bits;
    item_nxt.det      = in_ch.target_seen;
    item_nxt.seen     = in_ch.now_ms;
  end

  // sequencer: next state, table access and output load
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    rr_nxt        = rr_r;
    pos_nxt       = pos_r;
    next_poll_nxt = next_poll_r;
    item_ld       = 1'b0;
    out_ld        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = item_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r[IDX_W-1:0];

    unique case (state_r)
      anrr_pkg::ST_IDLE: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        lim_nxt    = cnt_r;
        if (in_acc) begin
          item_ld = 1'b1;
          if (in_ch.op == anrr_pkg::OP_POLL) begin
            // act only once the deadline has been reached
            if (!poll_diff[31]) begin
              next_poll_nxt = in_ch.now_ms + poll_period_r;
              state_nxt     = anrr_pkg::ST_PRUNE_RD;
            end
          end else if (in_ch.packet_length >= anrr_pkg::MIN_PACKET_LEN) begin
            state_nxt = anrr_pkg::ST_SRCH_RD;
          end
        end
      end

      anrr_pkg::ST_SRCH_RD: begin
        if (rd_ptr_r == cnt_r) begin
          // no match: append, or drop when full
          if (cnt_r == DEPTH_CNT) begin
            state_nxt = anrr_pkg::ST_IDLE;
          end else begin
            pos_nxt   = cnt_r[IDX_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = anrr_pkg::ST_WRITE;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = anrr_pkg::ST_SRCH_CHK;
        end
      end

      anrr_pkg::ST_SRCH_CHK: begin
        if (rd_q.id == item_r.id) begin
          pos_nxt   = rd_ptr_r[IDX_W-1:0];
          state_nxt = anrr_pkg::ST_WRITE;
        end else begin
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          state_nxt  = anrr_pkg::ST_SRCH_RD;
        end
      end

      anrr_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = anrr_pkg::ST_IDLE;
      end

      anrr_pkg::ST_PRUNE_RD: begin
        if (rd_ptr_r == lim_r) begin
          state_nxt = anrr_pkg::ST_PICK;
        end else begin
          mem_re    = 1'b1;
          state_nxt = anrr_pkg::ST_PRUNE_CHK;
        end
      end

      anrr_pkg::ST_PRUNE_CHK: begin
        if (age > stale_timeout_r) begin
          // drop the entry and pull the pointer along
          cnt_nxt = cnt_dec;
          rr_nxt  = (CNT_W'(rr_adj) >= cnt_dec) ? '0 : rr_adj;
        end else begin
          // keep the entry, compacted to the write position
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r[IDX_W-1:0];
          mem_wdata  = rd_q;
          wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        end
        rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        state_nxt  = anrr_pkg::ST_PRUNE_RD;
      end

      anrr_pkg::ST_PICK: begin
        if (cnt_r == '0) begin
          state_nxt = anrr_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rr_sel;
          rr_nxt    = rr_sel;
          state_nxt = anrr_pkg::ST_EMIT;
        end
      end

      anrr_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_ld        = 1'b1;
          out_valid_nxt = 1'b1;
          rr_nxt        = (CNT_W'(rr_r) + CNT_W'(1) == cnt_r) ? '0 : rr_r + IDX_W'(1);
          state_nxt     = anrr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = anrr_pkg::ST_IDLE;
      end
    endcase
  end

  // drive the result channel
  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_node_id       = out_q.id;
  assign out_ch.out_sender_ms     = out_q.sender;
  assign out_ch.out_distance_bits = out_q.distance;
  assign out_ch.out_angle_bits    = out_q.ang;
  assign out_ch.out_speed_bits    = out_q.spd;
  assign out_ch.out_target_seen   = out_q.det;

endmodule
